/* rtl/core/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants and types for the clock page replacement unit.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 20;
	localparam int FRAME_W   = 4;
	localparam int FUNC_W    = 2;
	localparam int CNT_W     = $clog2(2 * FRAMES);
	localparam int DATA_W    = ((FRAME_W + PAGE_BITS + 7) / 8) * 8;

	typedef logic [FRAME_W-1:0]   frame_t;
	typedef logic [PAGE_BITS-1:0] page_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_REF     = 2'd0,
		FN_FILL    = 2'd1,
		FN_REPLACE = 2'd2,
		FN_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_READ
	} state_t;

endpackage

/* rtl/core/clock_page_replacement_unit.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// Second-chance (clock) victim selection over a fixed set of page frames.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel: tuser carries the function
//   (reference, fill, replace, clear all reference bits), tdata the frame
//   index and the new page. Each command returns exactly one result on the
//   m_axis channel: tuser carries the found flag, tdata the victim frame and
//   the evicted page (all zero unless a replace found a victim).
//   Reference, fill and clear are done at the transfer; their result is valid
//   the cycle after it, and one command per cycle is taken while the result
//   register drains.
//   Replace walks the hand one frame per cycle through the valid and
//   reference flags, then reads the page memory of the victim in the
//   read state and loads the result; with no valid frame the walk stops
//   after two rounds and loads a not-found result.
//   The page memory has a single read port at the hand, which is why a
//   replace walks the hand. No command is taken during a replace.
//   Reset clears all valid and reference flags and the hand; page storage
//   is left as is. While m_axis_tready is low the result holds, and a new
//   command is taken only once the result register frees.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit
	import cpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // [3:0] frame_index, [23:4] new_page
	input  logic [FUNC_W-1:0] s_axis_tuser,  // [1:0] func
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // [3:0] victim_frame, [23:4] victim_page
	output logic              m_axis_tuser   // [0] found
);

	localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(2 * FRAMES - 1);
	localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAMES - 1);

	state_t state_q, state_next;

	logic [FRAMES-1:0] frame_valid_q;
	logic [FRAMES-1:0] frame_ref_q;
	frame_t            hand_q;
	frame_t            hand_next;
	logic [CNT_W-1:0]  cnt_q;
	frame_t            victim_q;
	page_t             page_q;
	page_t             rdata_q;
	page_t             page_mem [FRAMES];

	logic   out_valid_q;
	logic   out_found_q;
	frame_t out_frame_q;
	page_t  out_page_q;
	logic   out_load;

	func_t  in_func;
	frame_t in_frame;
	page_t  in_page;
	logic   in_xfer;
	logic   hit;

	logic   mem_we;
	frame_t mem_waddr;
	page_t  mem_wdata;

	assign in_func  = func_t'(s_axis_tuser);
	assign in_frame = s_axis_tdata[FRAME_W-1:0];
	assign in_page  = s_axis_tdata[FRAME_W+PAGE_BITS-1:FRAME_W];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign hit      = frame_valid_q[hand_q] && !frame_ref_q[hand_q];
	assign hand_next = (hand_q == FRAME_LAST) ? '0 : hand_q + 1'b1;

	// load a new result: simple command, sweep gave up, or victim read done
	assign out_load = (state_q == ST_IDLE && in_xfer && in_func != FN_REPLACE)
		|| (state_q == ST_SWEEP && !hit && cnt_q == CNT_LAST)
		|| (state_q == ST_READ);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && in_func == FN_REPLACE) state_next = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (hit) state_next = ST_READ;
				else if (cnt_q == CNT_LAST) state_next = ST_IDLE;
			end
			ST_READ: state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = in_frame;
		mem_wdata     = in_page;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = !out_valid_q || m_axis_tready;
				mem_we        = in_xfer && in_func == FN_FILL;
			end
			ST_READ: begin
				mem_we    = 1'b1;
				mem_waddr = victim_q;
				mem_wdata = page_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_valid_q <= '0;
			frame_ref_q   <= '0;
			hand_q        <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer) begin
						case (in_func)
							FN_REF:  frame_ref_q[in_frame] <= 1'b1;
							FN_FILL: begin
								frame_valid_q[in_frame] <= 1'b1;
								frame_ref_q[in_frame]   <= 1'b0;
							end
							FN_CLEAR: frame_ref_q <= '0;
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					hand_q <= hand_next;
					cnt_q  <= cnt_q + 1'b1;
					// second chance: drop the reference and move on
					if (!hit) frame_ref_q[hand_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) page_q <= in_page;
		if (state_q == ST_SWEEP) victim_q <= hand_q;
		if (state_q == ST_READ) begin
			out_found_q <= 1'b1;
			out_frame_q <= victim_q;
			out_page_q  <= rdata_q;
		end else if ((state_q == ST_IDLE && in_xfer) || (state_q == ST_SWEEP && !hit)) begin
			out_found_q <= 1'b0;
			out_frame_q <= '0;
			out_page_q  <= '0;
		end
	end

	// page storage: read at the hand every cycle, one write port
	always_ff @(posedge clk) begin
		if (mem_we) page_mem[mem_waddr] <= mem_wdata;
		rdata_q <= page_mem[hand_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = DATA_W'({out_page_q, out_frame_q});

	a_replace_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_REPLACE)
		|=> state_q == ST_SWEEP)
		else $error("replace transfer did not start a sweep");

	a_no_result_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result register busy during a replace");

	a_victim_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> frame_valid_q[m_axis_tdata[FRAME_W-1:0]])
		else $error("reported victim frame is not valid");

	a_victim_unreferenced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && hit) |=> !frame_ref_q[victim_q])
		else $error("chosen victim carries a reference");

endmodule
